>>> rtl/kvdp_pkg.sv
// ----------------------------------------------------------------------------
// kvdp_pkg
// Shared types and constants of the key/value decimal parser: character
// codes, status codes, configuration register indexes and the job record
// that travels from the line parser to the value builder.
// ----------------------------------------------------------------------------
package kvdp_pkg;

    localparam int KEY_MAX_CHARS        = 8;
    localparam int FRACTION_DIGITS_KEPT = 9;

    localparam int INT_W   = 31;
    localparam int FRAC_W  = 30;
    localparam int COUNT_W = 4;
    localparam int VALUE_W = 48;
    localparam int SUM_W   = 56;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NAME  = 2'd1;
    localparam logic [1:0] ST_VALUE = 2'd2;

    localparam int         CFG_IDX_W      = 1;
    localparam logic [0:0] CFG_KEY_CHARS  = 1'b0;
    localparam logic [0:0] CFG_KEY_LENGTH = 1'b1;

    localparam logic [INT_W-1:0]   INT_MAX = 31'h7FFF_FFFF;
    localparam logic [SUM_W-1:0]   MAG_MAX = 56'h0000_7FFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]         status;
        logic               neg;
        logic [INT_W-1:0]   int_part;
        logic [FRAC_W-1:0]  frac_part;
        logic [COUNT_W-1:0] frac_count;
    } job_t;

    function automatic logic [FRAC_W-1:0] pow10(input logic [COUNT_W-1:0] n);
        logic [FRAC_W-1:0] p;
        begin
            case (n)
                4'd0:    p = 30'd1;
                4'd1:    p = 30'd10;
                4'd2:    p = 30'd100;
                4'd3:    p = 30'd1000;
                4'd4:    p = 30'd10000;
                4'd5:    p = 30'd100000;
                4'd6:    p = 30'd1000000;
                4'd7:    p = 30'd10000000;
                4'd8:    p = 30'd100000000;
                4'd9:    p = 30'd1000000000;
                default: p = 30'd1;
            endcase
            return p;
        end
    endfunction

endpackage

>>> rtl/kvdp_if.sv
// ----------------------------------------------------------------------------
// kvdp channel interfaces
// Valid/ready channels of the parser: input characters, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface kvdp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

interface kvdp_result_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic signed [kvdp_pkg::VALUE_W-1:0] parsed_value;

    modport source (output valid, output status, output parsed_value, input ready);
    modport sink   (input valid, input status, input parsed_value, output ready);
endinterface

interface kvdp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [kvdp_pkg::CFG_IDX_W-1:0]   index;
    logic [63:0]                      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/key_value_decimal_parser.sv
// ----------------------------------------------------------------------------
// key_value_decimal_parser
// Checks "key=value" text lines and turns the decimal value into signed
// fixed point with FRACTION_BITS fraction bits.
//
// Usage:
//   cfg        : write index 0 (key characters, first in the low byte) and
//                index 1 (key length) while no line is in flight.
//   char_in    : one byte per transfer; a zero byte ends the line.
//   result_out : one transfer per line, a status and parsed_value.
// Throughput: the parser takes one byte per cycle while its 4-entry job
//   queue has room. A line with an error status passes from the queue
//   straight into the output register; a well-formed line holds the value
//   builder through its divide, sum and emit states, with the fraction
//   divider yielding one quotient bit per cycle. Each job is registered
//   in the queue before the value builder takes it.
// Reset clears the key registers, the parser state and the queue.
// When result_out stalls, results wait in the output register, then the
//   queue fills and char_in.ready drops until room frees up.
// ----------------------------------------------------------------------------
module key_value_decimal_parser #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    kvdp_char_if.sink           char_in,
    kvdp_cfg_if.sink            cfg,
    kvdp_result_if.source       result_out
);

    logic                 front_valid, front_ready;
    kvdp_pkg::job_t       front_job;
    logic                 back_valid, back_ready;
    kvdp_pkg::job_t       back_job;

    kvdp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_in),
        .cfg       (cfg),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    kvdp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_job   (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_job    (back_job)
    );

    kvdp_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (back_valid),
        .job_ready  (back_ready),
        .job        (back_job),
        .result_out (result_out)
    );

endmodule

>>> rtl/kvdp_front.sv
// ----------------------------------------------------------------------------
// kvdp_front
// Line parser: holds the key registers, matches the key and '=', collects
// sign, integer and fraction digits, and posts one job per line.
// ----------------------------------------------------------------------------
module kvdp_front (
    input  logic                clk,
    input  logic                rst_n,
    kvdp_char_if.sink           char_in,
    kvdp_cfg_if.sink            cfg,
    output logic                job_valid,
    input  logic                job_ready,
    output kvdp_pkg::job_t      job
);

    localparam logic [2:0] PH_KEY   = 3'd0;
    localparam logic [2:0] PH_SIGN  = 3'd1;
    localparam logic [2:0] PH_FIRST = 3'd2;
    localparam logic [2:0] PH_INT   = 3'd3;
    localparam logic [2:0] PH_FRAC  = 3'd4;
    localparam logic [2:0] PH_DRAIN = 3'd5;

    logic [63:0]                     key_chars_reg;
    logic [3:0]                      key_length_reg;
    logic [2:0]                      phase_reg, phase_next;
    logic [3:0]                      key_index_reg, key_index_next;
    logic                            neg_reg, neg_next;
    logic [kvdp_pkg::INT_W-1:0]      int_reg, int_next;
    logic [kvdp_pkg::FRAC_W-1:0]     frac_reg, frac_next;
    logic [kvdp_pkg::COUNT_W-1:0]    count_reg, count_next;

    logic                            fire;
    logic [7:0]                      c;
    logic [3:0]                      len;
    logic [7:0]                      key_byte;
    logic                            is_digit;
    logic                            is_end;
    logic [3:0]                      dval;
    logic [kvdp_pkg::INT_W+3:0]      int_x10;
    logic [kvdp_pkg::FRAC_W+3:0]     frac_x10;
    logic                            decide;
    logic [1:0]                      status;
    logic                            clear_line;

    assign cfg.ready     = 1'b1;
    assign char_in.ready = job_ready;
    assign fire          = char_in.valid & job_ready;
    assign c             = char_in.char_byte;

    assign len      = (key_length_reg > 4'(kvdp_pkg::KEY_MAX_CHARS))
                    ? 4'(kvdp_pkg::KEY_MAX_CHARS) : key_length_reg;
    assign key_byte = key_chars_reg[key_index_reg[2:0]*8 +: 8];
    assign is_digit = (c >= kvdp_pkg::CHAR_ZERO) && (c <= kvdp_pkg::CHAR_NINE);
    assign is_end   = (c == kvdp_pkg::CHAR_NUL) || (c == kvdp_pkg::CHAR_SPACE)
                   || (c == kvdp_pkg::CHAR_LF);
    assign dval     = c[3:0];

    assign int_x10  = ({4'b0, int_reg} << 3) + ({4'b0, int_reg} << 1)
                    + (kvdp_pkg::INT_W+4)'(dval);
    assign frac_x10 = ({4'b0, frac_reg} << 3) + ({4'b0, frac_reg} << 1)
                    + (kvdp_pkg::FRAC_W+4)'(dval);

    always_comb
    begin
        phase_next     = phase_reg;
        key_index_next = key_index_reg;
        neg_next       = neg_reg;
        int_next       = int_reg;
        frac_next      = frac_reg;
        count_next     = count_reg;
        decide         = 1'b0;
        status         = kvdp_pkg::ST_OK;
        clear_line     = 1'b0;

        if (fire)
        begin
            case (phase_reg)
                PH_KEY:
                begin
                    if (key_index_reg < len)
                    begin
                        if ((c == kvdp_pkg::CHAR_NUL) || (c != key_byte))
                        begin
                            decide = 1'b1;
                            status = kvdp_pkg::ST_NAME;
                        end
                        else
                        begin
                            key_index_next = key_index_reg + 4'd1;
                        end
                    end
                    else if (c != kvdp_pkg::CHAR_EQ)
                    begin
                        decide = 1'b1;
                        status = kvdp_pkg::ST_NAME;
                    end
                    else
                    begin
                        phase_next = PH_SIGN;
                    end
                end
                PH_SIGN, PH_FIRST:
                begin
                    if ((phase_reg == PH_SIGN) && (c == kvdp_pkg::CHAR_MINUS))
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_FIRST;
                    end
                    else if (!is_digit)
                    begin
                        decide = 1'b1;
                        status = kvdp_pkg::ST_VALUE;
                    end
                    else
                    begin
                        int_next   = kvdp_pkg::INT_W'(dval);
                        phase_next = PH_INT;
                    end
                end
                PH_INT:
                begin
                    if (c == kvdp_pkg::CHAR_DOT)
                    begin
                        phase_next = PH_FRAC;
                    end
                    else if (is_end)
                    begin
                        decide = 1'b1;
                        status = kvdp_pkg::ST_OK;
                    end
                    else if (!is_digit)
                    begin
                        decide = 1'b1;
                        status = kvdp_pkg::ST_VALUE;
                    end
                    else if (int_x10 > (kvdp_pkg::INT_W+4)'(kvdp_pkg::INT_MAX))
                    begin
                        int_next = kvdp_pkg::INT_MAX;
                    end
                    else
                    begin
                        int_next = int_x10[kvdp_pkg::INT_W-1:0];
                    end
                end
                PH_FRAC:
                begin
                    if (is_end)
                    begin
                        decide = 1'b1;
                        status = kvdp_pkg::ST_OK;
                    end
                    else if (!is_digit)
                    begin
                        decide = 1'b1;
                        status = kvdp_pkg::ST_VALUE;
                    end
                    else if (count_reg < kvdp_pkg::COUNT_W'(kvdp_pkg::FRACTION_DIGITS_KEPT))
                    begin
                        frac_next  = frac_x10[kvdp_pkg::FRAC_W-1:0];
                        count_next = count_reg + 4'd1;
                    end
                end
                default:
                begin
                    clear_line = (c == kvdp_pkg::CHAR_NUL);
                end
            endcase

            if (decide)
            begin
                if (c == kvdp_pkg::CHAR_NUL)
                    clear_line = 1'b1;
                else
                    phase_next = PH_DRAIN;
            end

            if (clear_line)
            begin
                phase_next     = PH_KEY;
                key_index_next = 4'd0;
                neg_next       = 1'b0;
                int_next       = '0;
                frac_next      = '0;
                count_next     = '0;
            end
        end
    end

    assign job_valid      = decide;
    assign job.status     = status;
    assign job.neg        = neg_reg;
    assign job.int_part   = int_reg;
    assign job.frac_part  = frac_reg;
    assign job.frac_count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_chars_reg  <= '0;
            key_length_reg <= '0;
            phase_reg      <= PH_KEY;
            key_index_reg  <= '0;
            neg_reg        <= 1'b0;
            int_reg        <= '0;
            frac_reg       <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    kvdp_pkg::CFG_KEY_CHARS:  key_chars_reg  <= cfg.data;
                    kvdp_pkg::CFG_KEY_LENGTH: key_length_reg <= cfg.data[3:0];
                    default:                  key_chars_reg  <= key_chars_reg;
                endcase
            end
            phase_reg     <= phase_next;
            key_index_reg <= key_index_next;
            neg_reg       <= neg_next;
            int_reg       <= int_next;
            frac_reg      <= frac_next;
            count_reg     <= count_next;
        end
    end

endmodule

>>> rtl/kvdp_queue.sv
// ----------------------------------------------------------------------------
// kvdp_queue
// Small job queue between the line parser and the value builder.
// ----------------------------------------------------------------------------
module kvdp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  kvdp_pkg::job_t      push_job,
    output logic                pop_valid,
    input  logic                pop_ready,
    output kvdp_pkg::job_t      pop_job
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    kvdp_pkg::job_t        slot_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]        fill_reg, fill_next;
    logic                  do_push, do_pop;

    assign push_ready = (fill_reg != (PTR_W+1)'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (!do_push && do_pop)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_next;
        end
    end

endmodule

>>> rtl/kvdp_back.sv
// ----------------------------------------------------------------------------
// kvdp_back
// Value builder: divides the fraction digits by the power of ten one
// quotient bit per cycle, adds the integer part, saturates, applies the
// sign and holds the result in the output register.
// ----------------------------------------------------------------------------
module kvdp_back #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  kvdp_pkg::job_t      job,
    kvdp_result_if.source       result_out
);

    localparam int STEP_W = $clog2(FRACTION_BITS);

    localparam logic [1:0] BK_IDLE = 2'd0;
    localparam logic [1:0] BK_DIV  = 2'd1;
    localparam logic [1:0] BK_SUM  = 2'd2;
    localparam logic [1:0] BK_EMIT = 2'd3;

    logic [1:0]                       state_reg, state_next;
    logic [STEP_W-1:0]                step_reg, step_next;
    logic [kvdp_pkg::FRAC_W-1:0]      rem_reg, rem_next;
    logic [kvdp_pkg::FRAC_W-1:0]      div_reg, div_next;
    logic [FRACTION_BITS-1:0]         quo_reg, quo_next;
    logic                             neg_reg, neg_next;
    logic [kvdp_pkg::INT_W-1:0]       int_reg, int_next;
    logic [kvdp_pkg::VALUE_W-2:0]     mag_reg, mag_next;
    logic                             out_valid_reg, out_valid_next;
    logic [1:0]                       out_status_reg, out_status_next;
    logic [kvdp_pkg::VALUE_W-1:0]     out_value_reg, out_value_next;

    logic                             out_free;
    logic [kvdp_pkg::FRAC_W:0]        rem2;
    logic                             fits;
    logic [kvdp_pkg::SUM_W-1:0]       sum;

    assign out_free  = !out_valid_reg || result_out.ready;
    assign job_ready = (state_reg == BK_IDLE) && out_free;

    assign rem2 = {rem_reg, 1'b0};
    assign fits = rem2 >= {1'b0, div_reg};
    assign sum  = (kvdp_pkg::SUM_W'(int_reg) << FRACTION_BITS)
                + kvdp_pkg::SUM_W'(quo_reg);

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        quo_next        = quo_reg;
        neg_next        = neg_reg;
        int_next        = int_reg;
        mag_next        = mag_reg;
        out_valid_next  = out_valid_reg && !result_out.ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid && out_free)
                begin
                    if (job.status == kvdp_pkg::ST_OK)
                    begin
                        rem_next   = job.frac_part;
                        div_next   = kvdp_pkg::pow10(job.frac_count);
                        quo_next   = '0;
                        neg_next   = job.neg;
                        int_next   = job.int_part;
                        step_next  = '0;
                        state_next = BK_DIV;
                    end
                    else
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = job.status;
                        out_value_next  = '0;
                    end
                end
            end
            BK_DIV:
            begin
                if (fits)
                    rem_next = rem2[kvdp_pkg::FRAC_W-1:0] - div_reg;
                else
                    rem_next = rem2[kvdp_pkg::FRAC_W-1:0];
                quo_next  = {quo_reg[FRACTION_BITS-2:0], fits};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(FRACTION_BITS - 1))
                    state_next = BK_SUM;
            end
            BK_SUM:
            begin
                if (sum > kvdp_pkg::MAG_MAX)
                    mag_next = kvdp_pkg::MAG_MAX[kvdp_pkg::VALUE_W-2:0];
                else
                    mag_next = sum[kvdp_pkg::VALUE_W-2:0];
                state_next = BK_EMIT;
            end
            default:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = kvdp_pkg::ST_OK;
                    if (neg_reg)
                        out_value_next = '0 - {1'b0, mag_reg};
                    else
                        out_value_next = {1'b0, mag_reg};
                    state_next = BK_IDLE;
                end
            end
        endcase
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.status       = out_status_reg;
    assign result_out.parsed_value = out_value_reg;

    always_ff @(posedge clk)
    begin
        step_reg       <= step_next;
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        quo_reg        <= quo_next;
        neg_reg        <= neg_next;
        int_reg        <= int_next;
        mag_reg        <= mag_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> bench/tb_key_value_decimal_parser.sv
// ----------------------------------------------------------------------------
// tb_key_value_decimal_parser
// Self-checking bench for the key/value decimal parser. A per-character
// predictor tracks key matching, sign, integer and fraction digits and
// builds the expected status and Q31.16 value for every line. Directed lines
// cover the number forms, error cases and key limits; then random
// well-formed, broken and noise lines run under several keys. The sender
// works in bursts and the result side stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb_key_value_decimal_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRACTION_BITS = 16;
    localparam int SETTLE_CYCLES = FRACTION_BITS + 12;
    localparam int RANDOM_CHARS  = 700;
    localparam int MAX_SHOWN     = 10;

    typedef enum logic [2:0] {
        LN_KEY,
        LN_SIGN,
        LN_FIRST,
        LN_INT,
        LN_FRAC,
        LN_DRAIN
    } line_phase_t;

    typedef struct packed {
        logic [1:0]                   status;
        logic [kvdp_pkg::VALUE_W-1:0] value;
    } line_result_t;

    typedef logic [7:0] char_q_t[$];

    logic clk = 1'b0;
    logic rst_n;

    kvdp_char_if   char_if();
    kvdp_cfg_if    cfg_if();
    kvdp_result_if result_if();

    key_value_decimal_parser #(
        .FRACTION_BITS(FRACTION_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_if),
        .cfg        (cfg_if),
        .result_out (result_if)
    );

    logic [63:0]    key_chars_q;
    logic [3:0]     key_length_q;
    line_phase_t    phase_q;
    logic [3:0]     key_idx_q;
    logic           neg_q;
    logic [30:0]    int_acc_q;
    logic [29:0]    frac_acc_q;
    logic [3:0]     frac_cnt_q;

    line_result_t   expected_lines[$];
    line_result_t   oldest_line;
    int             mismatches  = 0;
    int             parsed_chars = 0;
    int             burst_left  = 0;
    int             stall_left  = 0;
    int             stall_mode  = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic is_digit(input logic [7:0] c);
        return c >= kvdp_pkg::CHAR_ZERO && c <= kvdp_pkg::CHAR_NINE;
    endfunction

    function automatic logic is_end(input logic [7:0] c);
        return c == kvdp_pkg::CHAR_NUL || c == kvdp_pkg::CHAR_SPACE
            || c == kvdp_pkg::CHAR_LF;
    endfunction

    function automatic logic [63:0] pack_key(input string s);
        logic [63:0] k;
        k = '0;
        for (int i = 0; i < s.len() && i < kvdp_pkg::KEY_MAX_CHARS; i++)
            k[8*i +: 8] = s[i];
        return k;
    endfunction

    function automatic logic [kvdp_pkg::VALUE_W-1:0] fixed_value();
        logic [63:0] scale;
        logic [63:0] mag;
        scale = 64'd1;
        for (int i = 0; i < frac_cnt_q; i++)
            scale = scale * 10;
        mag = (64'(frac_acc_q) << FRACTION_BITS) / scale;
        mag = mag + (64'(int_acc_q) << FRACTION_BITS);
        if (mag > 64'h7FFF_FFFF_FFFF)
            mag = 64'h7FFF_FFFF_FFFF;
        if (neg_q)
            mag = 64'd0 - mag;
        return mag[kvdp_pkg::VALUE_W-1:0];
    endfunction

    task automatic clear_line();
        phase_q    = LN_KEY;
        key_idx_q  = '0;
        neg_q      = 1'b0;
        int_acc_q  = '0;
        frac_acc_q = '0;
        frac_cnt_q = '0;
    endtask

    task automatic close_line(input logic [1:0] status,
                              input logic [kvdp_pkg::VALUE_W-1:0] value,
                              input logic [7:0] c);
        expected_lines.push_back('{status: status, value: value});
        if (c == kvdp_pkg::CHAR_NUL)
            clear_line();
        else
            phase_q = LN_DRAIN;
    endtask

    task automatic predict_char(input logic [7:0] c);
        logic [3:0]  len;
        logic [63:0] acc;
        len = (key_length_q > kvdp_pkg::KEY_MAX_CHARS) ? 4'(kvdp_pkg::KEY_MAX_CHARS)
                                                       : key_length_q;
        if (phase_q != LN_DRAIN)
            parsed_chars++;
        case (phase_q)
            LN_KEY:
            begin
                if (key_idx_q < len)
                begin
                    if (c == kvdp_pkg::CHAR_NUL || c != key_chars_q[8*key_idx_q[2:0] +: 8])
                        close_line(kvdp_pkg::ST_NAME, '0, c);
                    else
                        key_idx_q++;
                end
                else if (c != kvdp_pkg::CHAR_EQ)
                    close_line(kvdp_pkg::ST_NAME, '0, c);
                else
                    phase_q = LN_SIGN;
            end
            LN_SIGN, LN_FIRST:
            begin
                if (phase_q == LN_SIGN && c == kvdp_pkg::CHAR_MINUS)
                begin
                    neg_q   = 1'b1;
                    phase_q = LN_FIRST;
                end
                else if (!is_digit(c))
                    close_line(kvdp_pkg::ST_VALUE, '0, c);
                else
                begin
                    int_acc_q = 31'(c - kvdp_pkg::CHAR_ZERO);
                    phase_q   = LN_INT;
                end
            end
            LN_INT:
            begin
                if (c == kvdp_pkg::CHAR_DOT)
                    phase_q = LN_FRAC;
                else if (is_end(c))
                    close_line(kvdp_pkg::ST_OK, fixed_value(), c);
                else if (!is_digit(c))
                    close_line(kvdp_pkg::ST_VALUE, '0, c);
                else
                begin
                    acc = 64'(int_acc_q) * 10 + 64'(c - kvdp_pkg::CHAR_ZERO);
                    if (acc > 64'(kvdp_pkg::INT_MAX))
                        acc = 64'(kvdp_pkg::INT_MAX);
                    int_acc_q = acc[30:0];
                end
            end
            LN_FRAC:
            begin
                if (is_end(c))
                    close_line(kvdp_pkg::ST_OK, fixed_value(), c);
                else if (!is_digit(c))
                    close_line(kvdp_pkg::ST_VALUE, '0, c);
                else if (frac_cnt_q < kvdp_pkg::FRACTION_DIGITS_KEPT)
                begin
                    frac_acc_q = frac_acc_q * 10 + 30'(c - kvdp_pkg::CHAR_ZERO);
                    frac_cnt_q++;
                end
            end
            default:
            begin
                if (c == kvdp_pkg::CHAR_NUL)
                    clear_line();
            end
        endcase
    endtask

    task automatic send_char(input logic [7:0] c);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
            char_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        burst_left--;
        char_if.valid     <= 1'b1;
        char_if.char_byte <= c;
        @(posedge clk);
        while (!char_if.ready)
            @(posedge clk);
        predict_char(c);
    endtask

    task automatic send_line(input char_q_t q);
        foreach (q[i])
            send_char(q[i]);
    endtask

    function automatic char_q_t text_line(input string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        q.push_back(kvdp_pkg::CHAR_NUL);
        return q;
    endfunction

    task automatic wait_idle();
        char_if.valid <= 1'b0;
        while (expected_lines.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [kvdp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        if (idx == kvdp_pkg::CFG_KEY_CHARS)
            key_chars_q = data;
        else
            key_length_q = data[3:0];
    endtask

    task automatic set_key(input logic [63:0] chars, input logic [3:0] len);
        wait_idle();
        write_reg(kvdp_pkg::CFG_KEY_CHARS, chars);
        write_reg(kvdp_pkg::CFG_KEY_LENGTH, 64'(len));
        cfg_if.valid <= 1'b0;
    endtask

    function automatic char_q_t random_line();
        char_q_t q;
        int      kind;
        int      len;
        kind = $urandom_range(0, 9);
        if (kind == 9)
        begin
            repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(1, 255)));
            q.push_back(kvdp_pkg::CHAR_NUL);
            return q;
        end
        len = (key_length_q > kvdp_pkg::KEY_MAX_CHARS) ? kvdp_pkg::KEY_MAX_CHARS
                                                       : key_length_q;
        for (int i = 0; i < len; i++)
            q.push_back(key_chars_q[8*i +: 8]);
        q.push_back(kvdp_pkg::CHAR_EQ);
        if ($urandom_range(0, 1) == 1)
            q.push_back(kvdp_pkg::CHAR_MINUS);
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(7, 13) : $urandom_range(1, 5))
            q.push_back(kvdp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 2) != 0)
        begin
            q.push_back(kvdp_pkg::CHAR_DOT);
            repeat ($urandom_range(0, 12))
                q.push_back(kvdp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        case ($urandom_range(0, 2))
            0:       q.push_back(kvdp_pkg::CHAR_NUL);
            1:       q.push_back(kvdp_pkg::CHAR_SPACE);
            default: q.push_back(kvdp_pkg::CHAR_LF);
        endcase
        if (q[q.size()-1] != kvdp_pkg::CHAR_NUL)
        begin
            repeat ($urandom_range(0, 4)) q.push_back(8'($urandom_range(1, 255)));
            q.push_back(kvdp_pkg::CHAR_NUL);
        end
        if (kind >= 7)
            q[$urandom_range(0, q.size() - 2)] = 8'($urandom_range(0, 255));
        return q;
    endfunction

    task automatic test_reset_key();
        send_line(text_line("=5"));
        send_line(text_line("a=1"));
        send_line(text_line(""));
    endtask

    task automatic test_number_forms();
        set_key(pack_key("temp"), 4'd4);
        send_line(text_line("temp=0"));
        send_line(text_line("temp=-0"));
        send_line(text_line("temp=2147483647"));
        send_line(text_line("temp=-99999999999"));
        send_line(text_line("temp=-12.5"));
        send_line(text_line("temp=1."));
        send_line(text_line("temp=3.14159265358979"));
        send_line(text_line("temp=0.999999999"));
        send_line(text_line("temp=42 junk"));
        send_line(text_line("temp=7\nx"));
        send_line(text_line("temp=1a"));
        send_line(text_line("temp=-"));
        send_line(text_line("temp="));
        send_line(text_line("temp=.5"));
        send_line(text_line("temp=1.2.3"));
        send_line(text_line("temp=1.x"));
        send_line(text_line("tem"));
        send_line(text_line("tamp=1"));
        send_line(text_line("temp1"));
    endtask

    task automatic test_key_limits();
        char_q_t q;
        set_key(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        repeat (kvdp_pkg::KEY_MAX_CHARS) q.push_back(8'hFF);
        q = {q, text_line("=1")};
        send_line(q);
        set_key(pack_key("abcdefgh"), 4'd15);
        send_line(text_line("abcdefgh=3.25"));
        send_line(text_line("abcdefghi=3"));
        set_key(pack_key("ab"), 4'd3);
        send_line(text_line("ab"));
        send_line(text_line("ab=1"));
        set_key(64'd0, 4'd0);
        send_line(text_line("=-1.5"));
    endtask

    task automatic test_random_lines();
        int          start;
        logic [63:0] chars;
        logic [3:0]  len;
        start = parsed_chars;
        while (parsed_chars - start < RANDOM_CHARS)
        begin
            for (int i = 0; i < kvdp_pkg::KEY_MAX_CHARS; i++)
                chars[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7E));
            len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
            set_key(chars, len);
            repeat (15) send_line(random_line());
        end
    endtask

    initial
    begin
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            case (stall_mode)
                0:       result_if.ready <= 1'b1;
                1:       result_if.ready <= ($urandom_range(0, 3) != 0);
                2:       result_if.ready <= ($urandom_range(0, 3) == 0);
                default: result_if.ready <= (stall_left % 5 == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_lines.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result: status %0d value %0d",
                             result_if.status, result_if.parsed_value);
            end
            else
            begin
                oldest_line = expected_lines.pop_front();
                if (result_if.status !== oldest_line.status
                    || result_if.parsed_value !== oldest_line.value)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"mismatch: expected status %0d value %0d, ",
                                  "got status %0d value %0d"},
                                 oldest_line.status, $signed(oldest_line.value),
                                 result_if.status, result_if.parsed_value);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        char_if.valid     <= 1'b0;
        char_if.char_byte <= kvdp_pkg::CHAR_NUL;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= kvdp_pkg::CFG_KEY_CHARS;
        cfg_if.data       <= '0;
        key_chars_q  = '0;
        key_length_q = '0;
        clear_line();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_key();
        test_number_forms();
        test_key_limits();
        test_random_lines();
        wait_idle();
        if (mismatches == 0 && expected_lines.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
